// File: rtl/core/kvfl_pkg.sv
// Shared types, constants and helpers for the key/value field lookup block.
package kvfl_pkg;

  localparam int unsigned KeyMaxChars = 8;
  localparam int unsigned CharW       = 8;
  localparam int unsigned KeyCharsW   = KeyMaxChars * CharW;
  localparam int unsigned KeyLenW     = 4;
  localparam int unsigned PosW        = 4;
  localparam int unsigned CharIdxW    = $clog2(KeyMaxChars) > 0 ? $clog2(KeyMaxChars) : 1;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = KeyCharsW;

  localparam logic [CharW-1:0] ChEquals  = 8'h3D;
  localparam logic [CharW-1:0] ChQuote   = 8'h22;
  localparam logic [CharW-1:0] ChNewline = 8'h0A;

  localparam logic [CfgIdxW-1:0] CfgIdxKeyChars  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxKeyLength = 1'b1;

  localparam logic [KeyLenW-1:0] KeyLenMax   = KeyLenW'(KeyMaxChars);
  localparam logic [KeyLenW-1:0] KeyLenReset = KeyLenW'(1);

  typedef enum logic [1:0] {
    PhMatch = 2'd0,
    PhSkip  = 2'd1,
    PhValue = 2'd2,
    PhDone  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [CharW-1:0] text_byte;
    logic             end_of_file;
  } req_t;

  typedef struct packed {
    logic [CharW-1:0] value_byte;
    logic             byte_valid;
    logic             value_done;
    logic             not_found;
  } rsp_t;

  typedef struct packed {
    logic [KeyCharsW-1:0] key_chars;
    logic [KeyLenW-1:0]   key_length;
  } cfg_t;

  function automatic logic [CharW-1:0] key_char(input logic [KeyCharsW-1:0] chars,
                                                 input logic [CharIdxW-1:0]  idx);
    logic [KeyCharsW-1:0] shifted;
    shifted = chars >> (CharW * idx);
    return shifted[CharW-1:0];
  endfunction

endpackage

// File: rtl/core/key_value_field_lookup.sv
// Top level of the key/value field lookup block.
// Takes one text byte per request and finds the first line key="value" whose key
// matches key_chars/key_length; emits the value bytes, then a done marker at the
// closing quote, or a not-found result at end of file. One request is accepted
// every cycle while in_ready_o is high; a request passes through the input register,
// then the scanner feeding the result register. in_ready_o drops only while a held
// result waits on out_ready_i. Configuration writes take effect the next cycle.
module key_value_field_lookup import kvfl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  req_t                in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsp_t                out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;
  logic advance;
  logic stage_valid;
  req_t stage_req;
  logic rsp_valid;
  rsp_t rsp;
  logic out_valid_q, out_valid_d;
  rsp_t out_q;

  assign advance = !out_valid_q || out_ready_i;

  kvfl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kvfl_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .req_o      (stage_req)
  );

  kvfl_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (stage_valid && advance),
    .req_i       (stage_req),
    .cfg_i       (cfg),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = rsp_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_rsp_has_meaning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.byte_valid || out_o.value_done || out_o.not_found))
    else $error("result carries no information");

  a_not_found_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.not_found) |-> (!out_o.byte_valid && !out_o.value_done))
    else $error("not_found mixed with value fields");

  a_empty_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.byte_valid) |-> (out_o.value_byte == '0))
    else $error("value_byte nonzero without byte_valid");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && stage_valid) |-> !in_ready_o)
    else $error("input taken while pipeline stalled");
`endif

endmodule

// File: rtl/core/kvfl_cfg_regs.sv
// Configuration registers: wanted key characters and key length.
module kvfl_cfg_regs import kvfl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgIdxKeyChars:  cfg_d.key_chars  = cfg_data_i[KeyCharsW-1:0];
        CfgIdxKeyLength: cfg_d.key_length = cfg_data_i[KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_chars  <= '0;
      cfg_q.key_length <= KeyLenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/kvfl_in_stage.sv
// Input register stage holding one request byte.
module kvfl_in_stage import kvfl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_i,
  input  logic advance_i,
  output logic valid_o,
  output req_t req_o
);

  logic valid_q, valid_d;
  req_t req_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// File: rtl/core/kvfl_scan.sv
// Line scanner: key match, line skip and value emission state machine.
module kvfl_scan import kvfl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [KeyLenW-1:0] len;
  logic [CharW-1:0]  b;
  logic              eof;

  assign len = (cfg_i.key_length > KeyLenMax) ? KeyLenMax : cfg_i.key_length;
  assign b   = req_i.text_byte;
  assign eof = req_i.end_of_file;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    rsp_valid_o = 1'b0;
    rsp_o       = '0;
    if (step_i) begin
      unique case (phase_q)
        PhMatch: begin
          if (b == ChNewline) begin
            pos_d = '0;
          end else if (pos_q < PosW'(len)) begin
            if (b == key_char(cfg_i.key_chars, pos_q[CharIdxW-1:0])) begin
              pos_d = pos_q + PosW'(1);
            end else begin
              phase_d = PhSkip;
            end
          end else if (pos_q == PosW'(len)) begin
            if (b == ChEquals) begin
              pos_d = pos_q + PosW'(1);
            end else begin
              phase_d = PhSkip;
            end
          end else begin
            phase_d = (b == ChQuote && !eof) ? PhValue : PhSkip;
          end
        end
        PhSkip: begin
          if (b == ChNewline) begin
            phase_d = PhMatch;
            pos_d   = '0;
          end
        end
        PhValue: begin
          rsp_valid_o = 1'b1;
          if (b == ChQuote) begin
            rsp_o.value_done = 1'b1;
            phase_d          = PhDone;
          end else begin
            rsp_o.value_byte = b;
            rsp_o.byte_valid = 1'b1;
            rsp_o.value_done = eof;
          end
        end
        PhDone: ;
        default: ;
      endcase
      if (eof) begin
        // file ended while still looking for the key
        if (phase_q == PhMatch || phase_q == PhSkip) begin
          rsp_valid_o     = 1'b1;
          rsp_o           = '0;
          rsp_o.not_found = 1'b1;
        end
        phase_d = PhMatch;
        pos_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMatch;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// File: dv/tb.sv
// Testbench for key_value_field_lookup: directed and random text files checked by a scan predictor.
`timescale 1ns / 1ps

module tb;
  import kvfl_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] text;
    logic             eof;
    logic             typed;
    logic             has_rsp;
    rsp_t             rsp;
  } dir_row_t;

  localparam rsp_t NoRsp = '0;
  localparam int NumDirRows = 24;
  localparam int NumSegments = 8;
  localparam int SegmentBytes = 140;

  // reset key: one character, byte 00
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{8'h00,     1'b0, 1'b0, 1'b0, NoRsp},
    '{ChEquals,  1'b0, 1'b0, 1'b0, NoRsp},
    '{ChQuote,   1'b0, 1'b0, 1'b0, NoRsp},
    '{8'h41,     1'b0, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0}},
    '{8'hFF,     1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{ChQuote,   1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{8'h41,     1'b1, 1'b1, 1'b0, NoRsp},
    // opening quote is the last byte
    '{8'h00,     1'b0, 1'b0, 1'b0, NoRsp},
    '{ChEquals,  1'b0, 1'b0, 1'b0, NoRsp},
    '{ChQuote,   1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
    // file ends inside the value
    '{8'h00,     1'b0, 1'b0, 1'b0, NoRsp},
    '{ChEquals,  1'b0, 1'b0, 1'b0, NoRsp},
    '{ChQuote,   1'b0, 1'b0, 1'b0, NoRsp},
    '{8'h00,     1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{8'hFF,     1'b1, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
    // skipped line, then a match
    '{8'h41,     1'b0, 1'b0, 1'b0, NoRsp},
    '{ChNewline, 1'b0, 1'b0, 1'b0, NoRsp},
    '{8'h00,     1'b0, 1'b0, 1'b0, NoRsp},
    '{ChEquals,  1'b0, 1'b0, 1'b0, NoRsp},
    '{ChQuote,   1'b0, 1'b0, 1'b0, NoRsp},
    '{ChNewline, 1'b0, 1'b1, 1'b1, '{8'h0A, 1'b1, 1'b0, 1'b0}},
    '{ChQuote,   1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
    // one-byte files
    '{ChNewline, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
    '{8'hFF,     1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  req_t                in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  rsp_t                out_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  logic [KeyCharsW-1:0] key_reg;
  logic [KeyLenW-1:0]   klen_reg;
  phase_e               scan_st;
  logic [PosW-1:0]      line_pos;
  rsp_t                 lookup_results[$];
  rsp_t                 head_rsp;
  logic [CharW-1:0]     file_text[$];
  int                   mismatches;
  int                   send_idle_pct;
  int                   recv_stall_pct;
  int                   bytes_sent;

  key_value_field_lookup uut (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // scanner state update for one request; returns 1 when a result is due
  function automatic logic scan_byte(input req_t r, output rsp_t res);
    logic [KeyLenW-1:0] len;
    logic               hit;
    len = (klen_reg > KeyLenMax) ? KeyLenMax : klen_reg;
    res = '0;
    hit = 1'b0;
    case (scan_st)
      PhMatch: begin
        if (r.text_byte == ChNewline) begin
          line_pos = '0;
        end else if (line_pos < len) begin
          if (r.text_byte == key_reg[{line_pos[2:0], 3'b000} +: CharW]) line_pos++;
          else scan_st = PhSkip;
        end else if (line_pos == len) begin
          if (r.text_byte == ChEquals) line_pos++;
          else scan_st = PhSkip;
        end else begin
          scan_st = (r.text_byte == ChQuote && !r.end_of_file) ? PhValue : PhSkip;
        end
      end
      PhSkip: begin
        if (r.text_byte == ChNewline) begin
          scan_st = PhMatch;
          line_pos = '0;
        end
      end
      PhValue: begin
        if (r.text_byte == ChQuote) begin
          res.value_done = 1'b1;
          scan_st = PhDone;
        end else begin
          res.value_byte = r.text_byte;
          res.byte_valid = 1'b1;
          res.value_done = r.end_of_file;
        end
        hit = 1'b1;
      end
      default: ;
    endcase
    if (r.end_of_file) begin
      if (scan_st == PhMatch || scan_st == PhSkip) begin
        res = '0;
        res.not_found = 1'b1;
        hit = 1'b1;
      end
      scan_st = PhMatch;
      line_pos = '0;
    end
    return hit;
  endfunction

  function automatic void flag_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t: %s: expected byte=%h valid=%b done=%b nf=%b, ",
                "got byte=%h valid=%b done=%b nf=%b"},
               $time, what, want.value_byte, want.byte_valid, want.value_done, want.not_found,
               got.value_byte, got.byte_valid, got.value_done, got.not_found);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lookup_results.size() == 0) begin
        flag_mismatch("result with nothing pending", NoRsp, out_o);
      end else begin
        head_rsp = lookup_results.pop_front();
        if (out_o.value_byte !== head_rsp.value_byte ||
            out_o.byte_valid !== head_rsp.byte_valid ||
            out_o.value_done !== head_rsp.value_done || out_o.not_found !== head_rsp.not_found)
          flag_mismatch("result mismatch", head_rsp, out_o);
      end
    end
  end

  task automatic send_byte(input logic [CharW-1:0] b, input logic eof, input logic typed,
                           input logic has_rsp, input rsp_t rsp);
    req_t r;
    rsp_t got;
    logic hit;
    r.text_byte = b;
    r.end_of_file = eof;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    hit = scan_byte(r, got);
    if (typed) begin
      hit = has_rsp;
      got = rsp;
    end
    if (hit) lookup_results.push_back(got);
    bytes_sent++;
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (lookup_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgIdxKeyChars) key_reg = data;
    else klen_reg = data[KeyLenW-1:0];
  endtask

  task automatic pick_key(input int seg);
    logic [KeyCharsW-1:0] chars;
    logic [KeyLenW-1:0]   n;
    for (int k = 0; k < KeyMaxChars; k++) chars[8*k +: 8] = 8'($urandom_range(8'h7A, 8'h61));
    case (seg)
      0: n = '0;
      1: begin
        chars = '1;
        n = '1;
      end
      2: begin
        chars = {$urandom, $urandom};
        n = KeyLenMax;
      end
      3: begin
        chars[15:8] = ChNewline;
        n = 4'd3;
      end
      4: n = 4'd9;
      6: begin
        chars = {$urandom, $urandom};
        n = 4'($urandom_range(15));
      end
      default: n = 4'($urandom_range(8, 1));
    endcase
    write_reg(CfgIdxKeyChars, chars);
    write_reg(CfgIdxKeyLength, CfgDataW'(n));
  endtask

  task automatic build_file();
    int               len;
    int               start;
    logic [CharW-1:0] v;
    file_text.delete();
    len = (klen_reg > KeyLenMax) ? KeyLenMax : klen_reg;
    repeat ($urandom_range(4, 1)) begin
      start = file_text.size();
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          for (int k = 0; k < len; k++) file_text.push_back(key_reg[8*k +: 8]);
          file_text.push_back(ChEquals);
          file_text.push_back(ChQuote);
          repeat ($urandom_range(6)) begin
            do v = 8'($urandom_range(255)); while (v == ChQuote);
            file_text.push_back(v);
          end
          if ($urandom_range(9) < 8) file_text.push_back(ChQuote);
          file_text.push_back(ChNewline);
        end
        5, 6: begin
          for (int k = 0; k < len; k++) file_text.push_back(key_reg[8*k +: 8]);
          case ($urandom_range(2))
            0: begin
              if (len > 0) file_text[start + $urandom_range(len - 1)] ^= 8'h01 << $urandom_range(7);
              file_text.push_back(ChEquals);
              file_text.push_back(ChQuote);
            end
            1: begin
              do v = 8'($urandom_range(255)); while (v == ChEquals);
              file_text.push_back(v);
              file_text.push_back(ChQuote);
            end
            default: begin
              file_text.push_back(ChEquals);
              do v = 8'($urandom_range(255)); while (v == ChQuote);
              file_text.push_back(v);
            end
          endcase
          file_text.push_back(8'($urandom_range(255)));
          file_text.push_back(ChNewline);
        end
        7: begin
          repeat ($urandom_range(6, 1)) file_text.push_back(8'($urandom_range(255)));
          file_text.push_back(ChNewline);
        end
        8: file_text.push_back(ChNewline);
        default: begin
          for (int k = 0; k < $urandom_range(len); k++) file_text.push_back(key_reg[8*k +: 8]);
          file_text.push_back(ChNewline);
        end
      endcase
    end
    if ($urandom_range(9) == 0) begin
      for (int k = 0; k < len; k++) file_text.push_back(key_reg[8*k +: 8]);
      file_text.push_back(ChEquals);
      file_text.push_back(ChQuote);
    end else if ($urandom_range(9) < 3) begin
      repeat ($urandom_range(file_text.size() - 1)) void'(file_text.pop_back());
    end
  endtask

  initial begin
    int seg_start;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    key_reg = '0;
    klen_reg = KeyLenReset;
    scan_st = PhMatch;
    line_pos = '0;
    mismatches = 0;
    bytes_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumDirRows; i++)
      send_byte(DirRows[i].text, DirRows[i].eof, DirRows[i].typed, DirRows[i].has_rsp,
                DirRows[i].rsp);
    wait_quiet();

    for (int seg = 0; seg < NumSegments; seg++) begin
      pick_key(seg);
      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct = 9;
          recv_stall_pct = 9;
        end
      endcase
      seg_start = bytes_sent;
      while (bytes_sent - seg_start < SegmentBytes) begin
        build_file();
        for (int i = 0; i < file_text.size(); i++)
          send_byte(file_text[i], i == file_text.size() - 1, 1'b0, 1'b0, NoRsp);
      end
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/kvfl_pkg.sv
rtl/core/kvfl_cfg_regs.sv
rtl/core/kvfl_in_stage.sv
rtl/core/kvfl_scan.sv
rtl/core/key_value_field_lookup.sv
dv/tb.sv
